// ----- rtl/ftrb_pkg.sv -----
`default_nettype none
package ftrb_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int FRAME_BYTES_DEF = 32;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        byte_valid;
		logic [7:0]  data_byte;
		logic        frame_end;
		logic        direction;
		logic [2:0]  sop_kind;
		logic [2:0]  frame_flags;
		logic [31:0] capture_time;
	} req_item_t;

	typedef struct packed {
		logic        record_present;
		logic        last;
		logic [31:0] out_capture_time;
		logic        out_direction;
		logic [2:0]  out_sop_kind;
		logic        out_goodcrc;
		logic        out_error;
		logic        out_reset;
		logic [5:0]  frame_length;
		logic        out_byte_valid;
		logic [7:0]  out_data_byte;
	} rsp_item_t;

	// header fields kept per record; the length travels beside it
	typedef struct packed {
		logic [31:0] ts;
		logic        dir;
		logic [2:0]  sop;
		logic        goodcrc;
		logic        err;
		logic        rst;
	} hdr_info_t;

	typedef struct packed {
		logic start;
		logic empty;
	} pop_req_t;

	typedef struct packed {
		logic hdr_en;
		logic byte_en;
	} rd_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/ftrb_store.sv -----
`default_nettype none
module ftrb_store #(
	parameter int DEPTH       = ftrb_pkg::DEPTH_DEF,
	parameter int FRAME_BYTES = ftrb_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          hdr_we,
	input  wire logic [$clog2(DEPTH)-1:0]                      hdr_waddr,
	input  wire ftrb_pkg::hdr_info_t                           hdr_winfo,
	input  wire logic [$clog2(FRAME_BYTES+1)-1:0]              hdr_wlen,
	input  wire logic                                          byte_we,
	input  wire logic [$clog2(DEPTH)+((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0]
	                                                           byte_waddr,
	input  wire logic [7:0]                                    byte_wdata,
	input  wire ftrb_pkg::rd_ctrl_t                            rd_ctrl,
	input  wire logic [$clog2(DEPTH)-1:0]                      hdr_raddr,
	input  wire logic [$clog2(DEPTH)+((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0]
	                                                           byte_raddr,
	output ftrb_pkg::hdr_info_t                                hdr_rinfo,
	output logic [$clog2(FRAME_BYTES+1)-1:0]                   hdr_rlen,
	output logic [7:0]                                         byte_rdata
);
	import ftrb_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int BW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int BYTE_DEPTH = DEPTH << BW;

	hdr_info_t        hdr_info_mem [DEPTH];
	logic [LW-1:0]    hdr_len_mem  [DEPTH];
	logic [7:0]       byte_mem     [BYTE_DEPTH];

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_info_mem[hdr_waddr] <= hdr_winfo;
			hdr_len_mem[hdr_waddr]  <= hdr_wlen;
		end
		if (rd_ctrl.hdr_en) begin
			hdr_rinfo <= hdr_info_mem[hdr_raddr];
			hdr_rlen  <= hdr_len_mem[hdr_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_waddr] <= byte_wdata;
		end
		// read data holds while no read is issued
		if (rd_ctrl.byte_en) begin
			byte_rdata <= byte_mem[byte_raddr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ftrb_pop_seq.sv -----
`default_nettype none
module ftrb_pop_seq #(
	parameter int DEPTH       = ftrb_pkg::DEPTH_DEF,
	parameter int FRAME_BYTES = ftrb_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire ftrb_pkg::pop_req_t                            pop_req,
	input  wire logic [$clog2(DEPTH)-1:0]                      pop_slot,
	output logic                                               idle,
	output ftrb_pkg::rd_ctrl_t                                 rd_ctrl,
	output logic [$clog2(DEPTH)-1:0]                           hdr_raddr,
	output logic [$clog2(DEPTH)+((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0]
	                                                           byte_raddr,
	input  wire ftrb_pkg::hdr_info_t                           hdr_rinfo,
	input  wire logic [$clog2(FRAME_BYTES+1)-1:0]              hdr_rlen,
	input  wire logic [7:0]                                    byte_rdata,
	output ftrb_pkg::rsp_item_t                                rsp,
	output logic                                               rsp_valid,
	input  wire logic                                          rsp_ready
);
	import ftrb_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int BW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int LW = $clog2(FRAME_BYTES + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_HEAD   = 3'b010,
		ST_STREAM = 3'b100
	} state_t;

	state_t        state_q;
	logic [SW-1:0] slot_q;
	logic [BW-1:0] k_q;
	logic [BW-1:0] last_idx_q;
	logic          empty_q;
	hdr_info_t     hdr_q;
	logic [LW-1:0] len_q;
	rsp_item_t     rsp_q;
	logic          rsp_valid_q;

	logic          out_free;
	logic          emit;
	logic          is_last;
	logic          has_bytes;
	rsp_item_t     rsp_d;

	assign idle      = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign emit      = (state_q == ST_STREAM) && out_free;
	assign is_last   = empty_q || (k_q == last_idx_q);
	assign has_bytes = !empty_q && (len_q != '0);

	assign rd_ctrl.hdr_en  = pop_req.start;
	assign rd_ctrl.byte_en = pop_req.start || (emit && !is_last);
	assign hdr_raddr       = pop_slot;
	assign byte_raddr      = idle ? {pop_slot, {BW{1'b0}}} : {slot_q, k_q + BW'(1)};

	always_comb begin
		rsp_d                  = '0;
		rsp_d.record_present   = !empty_q;
		rsp_d.last             = is_last;
		if (!empty_q) begin
			rsp_d.out_capture_time = hdr_q.ts;
			rsp_d.out_direction    = hdr_q.dir;
			rsp_d.out_sop_kind     = hdr_q.sop;
			rsp_d.out_goodcrc      = hdr_q.goodcrc;
			rsp_d.out_error        = hdr_q.err;
			rsp_d.out_reset        = hdr_q.rst;
			rsp_d.frame_length     = 6'(len_q);
		end
		rsp_d.out_byte_valid   = has_bytes;
		rsp_d.out_data_byte    = has_bytes ? byte_rdata : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_req.start) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= ST_STREAM;
				end
				ST_STREAM: begin
					if (emit && is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_req.start) begin
			slot_q  <= pop_slot;
			empty_q <= pop_req.empty;
			k_q     <= '0;
		end
		if (state_q == ST_HEAD) begin
			hdr_q      <= hdr_rinfo;
			len_q      <= hdr_rlen;
			// an empty record still gives one result
			last_idx_q <= (hdr_rlen == '0) ? '0 : BW'(hdr_rlen - LW'(1));
		end
		if (emit) begin
			rsp_q <= rsp_d;
			k_q   <= k_q + BW'(1);
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// ----- rtl/frame_trace_ring_buffer.sv -----
// Push and clear complete in the cycle they are accepted; one push per cycle while idle.
// A pop holds off the input until its last result: a header read, then one result per
// cycle unless the output stalls, paced by the single byte memory read port; one result
// per stored byte, at least one. The first result is registered in the stream state.
// Reset clears pointers, record count and the open-frame state; memories are not cleared.
`default_nettype none
module frame_trace_ring_buffer #(
	parameter int DEPTH       = ftrb_pkg::DEPTH_DEF,
	parameter int FRAME_BYTES = ftrb_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire ftrb_pkg::req_item_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output ftrb_pkg::rsp_item_t      rsp
);
	import ftrb_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int BW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int CW = $clog2(DEPTH + 1);

	logic [SW-1:0] rs_q;
	logic [SW-1:0] ws_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] fill_q;
	logic          open_q;
	logic          ovf_q;

	logic          acc;
	logic          acc_push;
	logic          acc_pop;
	logic          acc_clear;
	logic          seq_idle;
	logic [LW-1:0] fill_eff;
	logic          ovf_eff;
	logic          drop;
	logic          byte_fits;
	logic [LW-1:0] fill_new;
	logic          ovf_new;
	logic [CW-1:0] cnt_eff;
	logic [SW-1:0] rs_inc;
	logic [SW-1:0] ws_inc;

	pop_req_t      pop_req;
	rd_ctrl_t      rd_ctrl;
	hdr_info_t     hdr_winfo;
	hdr_info_t     hdr_rinfo;
	logic [LW-1:0] hdr_rlen;
	logic [7:0]    byte_rdata;
	logic [SW-1:0] hdr_raddr;
	logic [SW+BW-1:0] byte_raddr;

	assign req_ready = seq_idle;
	assign acc       = req_valid && req_ready;
	assign acc_push  = acc && (req.cmd == CMD_PUSH);
	assign acc_pop   = acc && (req.cmd == CMD_POP);
	assign acc_clear = acc && (req.cmd == CMD_CLEAR);

	// the first push of a frame starts from a clean fill state
	assign fill_eff  = open_q ? fill_q : '0;
	assign ovf_eff   = open_q && ovf_q;
	assign drop      = !open_q && (cnt_q == CW'(DEPTH));
	assign cnt_eff   = drop ? CW'(DEPTH - 1) : cnt_q;
	assign byte_fits = fill_eff < LW'(FRAME_BYTES);
	assign fill_new  = (req.byte_valid && byte_fits) ? fill_eff + LW'(1) : fill_eff;
	assign ovf_new   = ovf_eff || (req.byte_valid && !byte_fits);

	assign rs_inc = (rs_q == SW'(DEPTH - 1)) ? '0 : rs_q + SW'(1);
	assign ws_inc = (ws_q == SW'(DEPTH - 1)) ? '0 : ws_q + SW'(1);

	assign hdr_winfo.ts      = req.capture_time;
	assign hdr_winfo.dir     = req.direction;
	assign hdr_winfo.sop     = req.sop_kind;
	assign hdr_winfo.goodcrc = req.frame_flags[0];
	assign hdr_winfo.err     = req.frame_flags[1] || ovf_new;
	assign hdr_winfo.rst     = req.frame_flags[2];

	assign pop_req.start = acc_pop;
	assign pop_req.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q   <= '0;
			ws_q   <= '0;
			cnt_q  <= '0;
			fill_q <= '0;
			open_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (acc_clear) begin
			rs_q   <= '0;
			ws_q   <= '0;
			cnt_q  <= '0;
			fill_q <= '0;
			open_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (acc_push) begin
			if (drop) begin
				rs_q <= rs_inc;
			end
			if (req.frame_end) begin
				ws_q   <= ws_inc;
				cnt_q  <= (cnt_eff < CW'(DEPTH)) ? cnt_eff + CW'(1) : cnt_eff;
				fill_q <= '0;
				open_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				cnt_q  <= cnt_eff;
				fill_q <= fill_new;
				open_q <= 1'b1;
				ovf_q  <= ovf_new;
			end
		end else if (acc_pop && (cnt_q != '0)) begin
			rs_q  <= rs_inc;
			cnt_q <= cnt_q - CW'(1);
		end
	end

	ftrb_store #(
		.DEPTH       (DEPTH),
		.FRAME_BYTES (FRAME_BYTES)
	) u_store (
		.clk        (clk),
		.hdr_we     (acc_push && req.frame_end),
		.hdr_waddr  (ws_q),
		.hdr_winfo  (hdr_winfo),
		.hdr_wlen   (fill_new),
		.byte_we    (acc_push && req.byte_valid && byte_fits),
		.byte_waddr ({ws_q, fill_eff[BW-1:0]}),
		.byte_wdata (req.data_byte),
		.rd_ctrl    (rd_ctrl),
		.hdr_raddr  (hdr_raddr),
		.byte_raddr (byte_raddr),
		.hdr_rinfo  (hdr_rinfo),
		.hdr_rlen   (hdr_rlen),
		.byte_rdata (byte_rdata)
	);

	ftrb_pop_seq #(
		.DEPTH       (DEPTH),
		.FRAME_BYTES (FRAME_BYTES)
	) u_pop_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_req    (pop_req),
		.pop_slot   (rs_q),
		.idle       (seq_idle),
		.rd_ctrl    (rd_ctrl),
		.hdr_raddr  (hdr_raddr),
		.byte_raddr (byte_raddr),
		.hdr_rinfo  (hdr_rinfo),
		.hdr_rlen   (hdr_rlen),
		.byte_rdata (byte_rdata),
		.rsp        (rsp),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("record count above ring depth");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(FRAME_BYTES))
		else $error("fill count above frame size");

	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (fill_q == '0) && !ovf_q)
		else $error("fill state left over with no open frame");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_pop && (cnt_q == '0)) |=> (cnt_q == '0) && $stable(rs_q))
		else $error("pop of empty ring moved the ring");

endmodule
`default_nettype wire

// ----- tb/sv/frame_trace_ring_buffer_test.sv -----
`timescale 1ns / 1ps
module frame_trace_ring_buffer_test;
	import ftrb_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int FRAME_BYTES  = FRAME_BYTES_DEF;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int SETTLE       = 64;
	localparam int PRINT_CAP    = 40;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef logic [$clog2(DEPTH)-1:0] slot_t;
	typedef logic [$clog2(DEPTH):0]   count_t;

	typedef struct {
		req_item_t item;
		int        reps;
		bit        typed;
		rsp_item_t want;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	req_item_t req       = '0;
	logic      rsp_ready = 1'b0;
	logic      req_ready;
	logic      rsp_valid;
	rsp_item_t rsp;

	frame_trace_ring_buffer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// ring model
	slot_t                  rd_slot, wr_slot;
	count_t                 n_records;
	logic [5:0]             fill;
	logic                   frame_active, truncated;
	hdr_info_t              hdr_mem [DEPTH];
	logic [5:0]             len_mem [DEPTH];
	logic [7:0]             byte_mem [DEPTH][FRAME_BYTES];

	rsp_item_t expected_rsp [$];
	stim_row_t dir_rows [$];

	int  errors, cycle_count, items_sent, results_checked;
	int  frames_committed, frames_cut, pops_seen, overwrites, clears, ignored;
	bit  calm_link = 1'b1;
	rsp_item_t mon_want;

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_CAP)
			$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				results_checked, name, got, want));
	endtask

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic req_item_t frame_item(input logic [1:0] cmd, input logic bv,
			input logic [7:0] data, input logic fe, input logic dir,
			input logic [2:0] sop, input logic [2:0] flags, input logic [31:0] ts);
		req_item_t it;
		it.cmd          = cmd;
		it.byte_valid   = bv;
		it.data_byte    = data;
		it.frame_end    = fe;
		it.direction    = dir;
		it.sop_kind     = sop;
		it.frame_flags  = flags;
		it.capture_time = ts;
		return it;
	endfunction

	function automatic req_item_t random_item(input logic [1:0] cmd);
		return frame_item(cmd, 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
			3'($urandom), 3'($urandom), $urandom);
	endfunction

	task automatic ring_step(input req_item_t it);
		hdr_info_t h;
		rsp_item_t r;
		int        cnt;
		case (it.cmd)
			CMD_PUSH: begin
				if (!frame_active) begin
					if (n_records == DEPTH) begin
						rd_slot++;
						n_records = count_t'(DEPTH - 1);
						overwrites++;
					end
					frame_active = 1'b1;
					fill = '0;
					truncated = 1'b0;
				end
				if (it.byte_valid) begin
					if (fill < FRAME_BYTES) begin
						byte_mem[wr_slot][fill] = it.data_byte;
						fill++;
					end else begin
						truncated = 1'b1;
					end
				end
				if (it.frame_end) begin
					h.ts      = it.capture_time;
					h.dir     = it.direction;
					h.sop     = it.sop_kind;
					h.goodcrc = it.frame_flags[0];
					h.err     = it.frame_flags[1] | truncated;
					h.rst     = it.frame_flags[2];
					hdr_mem[wr_slot] = h;
					len_mem[wr_slot] = fill;
					frames_committed++;
					if (truncated)
						frames_cut++;
					wr_slot++;
					if (n_records < DEPTH)
						n_records++;
					frame_active = 1'b0;
					fill = '0;
					truncated = 1'b0;
				end
			end
			CMD_POP: begin
				pops_seen++;
				if (n_records == 0) begin
					r = '0;
					r.last = 1'b1;
					expected_rsp.push_back(r);
				end else begin
					h = hdr_mem[rd_slot];
					cnt = (len_mem[rd_slot] == 0) ? 1 : len_mem[rd_slot];
					for (int k = 0; k < cnt; k++) begin
						r.record_present   = 1'b1;
						r.last             = (k == cnt - 1);
						r.out_capture_time = h.ts;
						r.out_direction    = h.dir;
						r.out_sop_kind     = h.sop;
						r.out_goodcrc      = h.goodcrc;
						r.out_error        = h.err;
						r.out_reset        = h.rst;
						r.frame_length     = len_mem[rd_slot];
						r.out_byte_valid   = (len_mem[rd_slot] != 0);
						r.out_data_byte    = (len_mem[rd_slot] != 0) ?
							byte_mem[rd_slot][k] : 8'd0;
						expected_rsp.push_back(r);
					end
					rd_slot++;
					n_records--;
				end
			end
			CMD_CLEAR: begin
				clears++;
				rd_slot = '0;
				wr_slot = '0;
				n_records = '0;
				fill = '0;
				frame_active = 1'b0;
				truncated = 1'b0;
			end
			default: ignored++;
		endcase
	endtask

	// valid stays up across back-to-back transactions; only one NBA per edge
	task automatic send_item(input req_item_t it);
		int gap;
		gap = calm_link ? 0 : idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		ring_step(it);
		if (it.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_frame();
		int len, k;
		bit tail_byte;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			len = 0;
		else if (r < 85)
			len = $urandom_range(1, 6);
		else if (r < 95)
			len = $urandom_range(7, FRAME_BYTES - 1);
		else
			len = $urandom_range(FRAME_BYTES, FRAME_BYTES + 8);
		tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (k = 0; k < len - tail_byte; k++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				// abandon the frame part way through
				send_item(random_item(CMD_CLEAR));
				return;
			end else if (r < 7) begin
				send_item(random_item(CMD_POP));
			end else if (r < 11) begin
				send_item(frame_item(CMD_PUSH, 1'b0, 8'($urandom), 1'b0, 1'($urandom),
					3'($urandom), 3'($urandom), $urandom));
			end
			send_item(frame_item(CMD_PUSH, 1'b1, 8'($urandom), 1'b0, 1'($urandom),
				3'($urandom), 3'($urandom), $urandom));
		end
		send_item(frame_item(CMD_PUSH, tail_byte, 8'($urandom), 1'b1, 1'($urandom),
			3'($urandom), 3'($urandom), $urandom));
	endtask

	task automatic add_row(input req_item_t it, input int reps, input bit typed,
			input rsp_item_t want);
		stim_row_t row;
		row.item  = it;
		row.reps  = reps;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_rsp.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: %h", rsp));
			end else begin
				mon_want = expected_rsp.pop_front();
				check_field("record_present", 32'(rsp.record_present),
					32'(mon_want.record_present));
				check_field("last", 32'(rsp.last), 32'(mon_want.last));
				check_field("out_capture_time", rsp.out_capture_time,
					mon_want.out_capture_time);
				check_field("out_direction", 32'(rsp.out_direction),
					32'(mon_want.out_direction));
				check_field("out_sop_kind", 32'(rsp.out_sop_kind),
					32'(mon_want.out_sop_kind));
				check_field("out_goodcrc", 32'(rsp.out_goodcrc),
					32'(mon_want.out_goodcrc));
				check_field("out_error", 32'(rsp.out_error), 32'(mon_want.out_error));
				check_field("out_reset", 32'(rsp.out_reset), 32'(mon_want.out_reset));
				check_field("frame_length", 32'(rsp.frame_length),
					32'(mon_want.frame_length));
				check_field("out_byte_valid", 32'(rsp.out_byte_valid),
					32'(mon_want.out_byte_valid));
				check_field("out_data_byte", 32'(rsp.out_data_byte),
					32'(mon_want.out_data_byte));
			end
			results_checked++;
		end
	end

	// result side back-pressure
	initial begin
		int n;
		forever begin
			n = calm_link ? 0 : idle_gap();
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		rsp_item_t w;
		req_item_t it;
		int        r, pop_pct;

		rd_slot = '0;
		wr_slot = '0;
		n_records = '0;
		fill = '0;
		frame_active = 1'b0;
		truncated = 1'b0;

		// empty pop straight after reset
		w = '0;
		w.last = 1'b1;
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b1, w);
		// empty frame, every header field at its top
		add_row(frame_item(CMD_PUSH, 1'b0, 8'h00, 1'b1, 1'b1, 3'd7, 3'd7, 32'hFFFF_FFFF),
			1, 1'b0, w);
		w = '0;
		w.record_present = 1'b1;
		w.last = 1'b1;
		w.out_capture_time = 32'hFFFF_FFFF;
		w.out_direction = 1'b1;
		w.out_sop_kind = 3'd7;
		w.out_goodcrc = 1'b1;
		w.out_error = 1'b1;
		w.out_reset = 1'b1;
		add_row(frame_item(CMD_POP, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd7, 3'd7, 32'hFFFF_FFFF),
			1, 1'b1, w);
		// single-byte frame, header at the bottom
		add_row(frame_item(CMD_PUSH, 1'b1, 8'hFF, 1'b1, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b0, w);
		w = '0;
		w.record_present = 1'b1;
		w.last = 1'b1;
		w.frame_length = 6'd1;
		w.out_byte_valid = 1'b1;
		w.out_data_byte = 8'hFF;
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b1, w);
		add_row(frame_item(CMD_UNUSED, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd7, 3'd7, 32'hFFFF_FFFF),
			1, 1'b0, w);
		// exactly full frame, then one cut short
		add_row(frame_item(CMD_PUSH, 1'b1, 8'h00, 1'b0, 1'b0, 3'd2, 3'd0, 32'h100),
			FRAME_BYTES, 1'b0, w);
		add_row(frame_item(CMD_PUSH, 1'b0, 8'h00, 1'b1, 1'b1, 3'd5, 3'd1, 32'h8000_0001),
			1, 1'b0, w);
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b0, w);
		add_row(frame_item(CMD_PUSH, 1'b1, 8'h40, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			FRAME_BYTES + 3, 1'b0, w);
		add_row(frame_item(CMD_PUSH, 1'b1, 8'hAA, 1'b1, 1'b0, 3'd1, 3'd0, 32'h1234_5678),
			1, 1'b0, w);
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b0, w);
		// pop with a frame open and nothing committed
		add_row(frame_item(CMD_PUSH, 1'b1, 8'h11, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b0, w);
		w = '0;
		w.last = 1'b1;
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b1, w);
		add_row(frame_item(CMD_PUSH, 1'b0, 8'h99, 1'b0, 1'b1, 3'd6, 3'd7, 32'hDEAD_BEEF),
			1, 1'b0, w);
		add_row(frame_item(CMD_PUSH, 1'b1, 8'h22, 1'b1, 1'b0, 3'd3, 3'd4, 32'h0000_0042),
			1, 1'b0, w);
		// overfill the ring with empty frames, then open one more to drop the oldest
		add_row(frame_item(CMD_PUSH, 1'b0, 8'h00, 1'b1, 1'b1, 3'd4, 3'd2, 32'h7000_0000),
			DEPTH + 2, 1'b0, w);
		add_row(frame_item(CMD_PUSH, 1'b1, 8'h77, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b0, w);
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			3, 1'b0, w);
		// clear abandons the open frame
		add_row(frame_item(CMD_CLEAR, 1'b1, 8'hFF, 1'b1, 1'b1, 3'd7, 3'd7, 32'hFFFF_FFFF),
			1, 1'b0, w);
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b1, w);
		add_row(frame_item(CMD_PUSH, 1'b1, 8'h5A, 1'b1, 1'b1, 3'd1, 3'd5, 32'h0000_FFFF),
			1, 1'b0, w);
		add_row(frame_item(CMD_POP, 1'b0, 8'h00, 1'b0, 1'b0, 3'd0, 3'd0, 32'h0),
			1, 1'b0, w);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm_link = 1'b1;
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				it = dir_rows[i].item;
				it.data_byte = dir_rows[i].item.data_byte + 8'(k);
				it.capture_time = dir_rows[i].item.capture_time + 32'(k);
				send_item(it);
				if (dir_rows[i].typed)
					expected_rsp[expected_rsp.size() - 1] = dir_rows[i].want;
			end
		end
		wait_drain();

		// random traffic in four phases; the sender holds off until drained between them
		items_sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			calm_link = (phase == 0);
			case (phase)
				0: pop_pct = 25;
				1: pop_pct = 12;
				2: pop_pct = 50;
				default: pop_pct = 35;
			endcase
			while (items_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_item(random_item(CMD_CLEAR));
				else if (r < 6)
					send_item(random_item(CMD_UNUSED));
				else if (r < 6 + pop_pct)
					send_item(random_item(CMD_POP));
				else
					random_frame();
			end
			wait_drain();
		end

		// drain whatever is left in the ring
		calm_link = 1'b0;
		while (n_records != 0)
			send_item(random_item(CMD_POP));
		wait_drain();
		repeat (SETTLE) @(posedge clk);

		$display("run: %0d frames committed (%0d cut short), %0d pops, %0d results checked",
			frames_committed, frames_cut, pops_seen, results_checked);
		$display("run: %0d oldest records overwritten, %0d clears, %0d unused commands",
			overwrites, clears, ignored);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
